### sv/tkh_pkg.sv
// Shared constants, types and field layout for the top-K min-heap tracker.
// Used by tkh_sift and top_k_min_heap_running_sum; depends on nothing.
`timescale 1ns / 1ps

package tkh_pkg;

  localparam int DEPTH    = 1024;
  localparam int ADDR_W   = $clog2(DEPTH);
  localparam int CNT_W    = ADDR_W + 1;
  localparam int VALUE_W  = 32;
  localparam int DELTA_W  = VALUE_W + 1;
  localparam int SUM_W    = 48;

  // Result packing on the master-side tdata, lowest bit first
  localparam int TOTAL_LSB = 0;
  localparam int COUNT_LSB = TOTAL_LSB + SUM_W;
  localparam int ROOT_LSB  = COUNT_LSB + CNT_W;
  localparam int KEPT_BIT  = ROOT_LSB + VALUE_W;
  localparam int RES_W     = KEPT_BIT + 1;
  localparam int OUT_W     = ((RES_W + 7) / 8) * 8;

  localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

  // Item kinds carried on tuser
  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_REPORT = 1'b1;

  // Request from the top level to the sift sequencer
  typedef struct packed {
    logic                      start;
    logic                      down;
    logic [ADDR_W-1:0]         pos;
    logic signed [VALUE_W-1:0] value;
    logic [CNT_W-1:0]          n;
  } sift_cmd_t;

endpackage

### sv/tkh_sift.sv
// Heap store and sift sequencer: one memory read port, one write port, and
// compare logic that walks one heap level per step. Depends on tkh_pkg.
`timescale 1ns / 1ps

module tkh_sift (
  input  logic                              clk,
  input  logic                              rst,
  input  tkh_pkg::sift_cmd_t                cmd,
  output logic                              done,
  output logic signed [tkh_pkg::VALUE_W-1:0] root
);

  typedef enum logic [5:0] {
    SF_IDLE   = 6'b000001,
    SF_UP_RD  = 6'b000010,
    SF_UP_CMP = 6'b000100,
    SF_DN_RDA = 6'b001000,
    SF_DN_RDB = 6'b010000,
    SF_DN_CMP = 6'b100000
  } sift_state_t;

  sift_state_t                        state, state_next;
  logic [tkh_pkg::ADDR_W-1:0]         pos, pos_next;
  logic signed [tkh_pkg::VALUE_W-1:0] carry;
  logic [tkh_pkg::CNT_W-1:0]          n;
  logic signed [tkh_pkg::VALUE_W-1:0] a_val;
  logic                               done_next;

  logic [tkh_pkg::VALUE_W-1:0]        mem [tkh_pkg::DEPTH];
  logic signed [tkh_pkg::VALUE_W-1:0] rd_data;
  logic                               rd_en;
  logic [tkh_pkg::ADDR_W-1:0]         rd_addr;
  logic                               wr_en;
  logic [tkh_pkg::ADDR_W-1:0]         wr_addr;
  logic signed [tkh_pkg::VALUE_W-1:0] wr_data;

  logic [tkh_pkg::ADDR_W-1:0]         pos_m1;
  logic [tkh_pkg::ADDR_W-1:0]         parent;
  logic [tkh_pkg::ADDR_W+1:0]         child_a;
  logic [tkh_pkg::ADDR_W+1:0]         child_b;
  logic [tkh_pkg::ADDR_W+1:0]         n_ext;
  logic                               a_ok;
  logic                               b_ok;
  logic                               a_less;
  logic signed [tkh_pkg::VALUE_W-1:0] best_v;
  logic                               b_less;

  // Tree neighbors of the current hole
  assign pos_m1  = pos - tkh_pkg::ADDR_W'(1);
  assign parent  = {1'b0, pos_m1[tkh_pkg::ADDR_W-1:1]};
  assign child_a = {1'b0, pos, 1'b1};
  assign child_b = child_a + (tkh_pkg::ADDR_W+2)'(1);
  assign n_ext   = {1'b0, n};
  assign a_ok    = child_a < n_ext;
  assign b_ok    = child_b < n_ext;

  // Pick the smallest of hole value and the two children
  assign a_less = a_val < carry;
  assign best_v = a_less ? a_val : carry;
  assign b_less = b_ok && (rd_data < best_v);

  // Sequencer: the carried value moves as a hole, parent or child shifts in
  always_comb begin
    state_next = state;
    pos_next   = pos;
    done_next  = 1'b0;
    rd_en      = 1'b0;
    rd_addr    = child_a[tkh_pkg::ADDR_W-1:0];
    wr_en      = 1'b0;
    wr_addr    = pos;
    wr_data    = carry;
    unique case (state)
      SF_IDLE: begin
        if (cmd.start) begin
          pos_next   = cmd.pos;
          state_next = cmd.down ? SF_DN_RDA : SF_UP_RD;
        end
      end
      SF_UP_RD: begin
        if (pos == '0) begin
          wr_en      = 1'b1;
          done_next  = 1'b1;
          state_next = SF_IDLE;
        end else begin
          rd_en      = 1'b1;
          rd_addr    = parent;
          state_next = SF_UP_CMP;
        end
      end
      SF_UP_CMP: begin
        wr_en = 1'b1;
        if (rd_data > carry) begin
          wr_data    = rd_data;
          pos_next   = parent;
          state_next = SF_UP_RD;
        end else begin
          done_next  = 1'b1;
          state_next = SF_IDLE;
        end
      end
      SF_DN_RDA: begin
        if (!a_ok) begin
          wr_en      = 1'b1;
          done_next  = 1'b1;
          state_next = SF_IDLE;
        end else begin
          rd_en      = 1'b1;
          state_next = SF_DN_RDB;
        end
      end
      SF_DN_RDB: begin
        rd_en      = b_ok;
        rd_addr    = child_b[tkh_pkg::ADDR_W-1:0];
        state_next = SF_DN_CMP;
      end
      SF_DN_CMP: begin
        wr_en = 1'b1;
        priority if (b_less) begin
          wr_data    = rd_data;
          pos_next   = child_b[tkh_pkg::ADDR_W-1:0];
          state_next = SF_DN_RDA;
        end else if (a_less) begin
          wr_data    = a_val;
          pos_next   = child_a[tkh_pkg::ADDR_W-1:0];
          state_next = SF_DN_RDA;
        end else begin
          done_next  = 1'b1;
          state_next = SF_IDLE;
        end
      end
      default: begin
        state_next = SF_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= SF_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= done_next;
    end
  end

  // Payload registers and root copy
  always_ff @(posedge clk) begin
    pos <= pos_next;
    if (state == SF_IDLE && cmd.start) begin
      carry <= cmd.value;
      n     <= cmd.n;
    end
    if (state == SF_DN_RDB) begin
      a_val <= rd_data;
    end
    if (wr_en && wr_addr == '0) begin
      root <= wr_data;
    end
  end

  // Heap store
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### sv/top_k_min_heap_running_sum.sv
// Top level of the top-K tracker: stream handshake, limit register, fill
// count and saturating sum. Depends on tkh_pkg and tkh_sift.
`timescale 1ns / 1ps

// Keeps the K largest signed 32-bit values seen so far in a binary min-heap
// of 1024 entries, plus their 48-bit saturating sum. Each request on the
// slave stream (tuser 0 insert, 1 report) returns one result with the sum,
// count, smallest kept value (zero when empty) and a kept flag. Requests are
// taken one at a time. A report or a discarded value goes straight to the
// result; an append sifts up from the end of the heap, and a root replace
// sifts down from the root. Sifting is paced by the single read port of the
// heap memory, which the sift sequencer uses once or twice per level. The
// heap memory needs no clearing after reset, so requests are taken at once.
// keep_limit (K) is written through cfg_we/cfg_wdata; the user must write it
// only while the block is idle, which the block itself does not enforce. 0
// acts as 1 and values above 1024 act as 1024. Lowering K evicts nothing.
module top_k_min_heap_running_sum (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [31:0]                 s_axis_tdata,  // [31:0] value
  input  logic                        s_axis_tuser,  // [0] action
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  // [47:0] total, [58:48] held_count, [90:59] smallest_kept, [91] was_kept
  output logic [tkh_pkg::OUT_W-1:0]   m_axis_tdata,
  input  logic                        cfg_we,
  input  logic [tkh_pkg::CNT_W-1:0]   cfg_wdata
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SIFT = 3'b010,
    ST_DONE = 3'b100
  } top_state_t;

  top_state_t                          state;
  logic [tkh_pkg::CNT_W-1:0]           keep_limit;
  logic [tkh_pkg::CNT_W-1:0]           fill;
  logic signed [tkh_pkg::SUM_W-1:0]    sum;
  logic signed [tkh_pkg::DELTA_W-1:0]  delta;
  logic                                kept;

  logic [tkh_pkg::CNT_W-1:0]           limit;
  logic                                accept;
  logic signed [tkh_pkg::VALUE_W-1:0]  value;
  logic                                do_append;
  logic                                do_replace;
  tkh_pkg::sift_cmd_t                  cmd;
  logic                                sift_done;
  logic signed [tkh_pkg::VALUE_W-1:0]  root;
  logic signed [tkh_pkg::SUM_W:0]      sum_wide;
  logic signed [tkh_pkg::SUM_W-1:0]    sum_sat;
  logic signed [tkh_pkg::SUM_W-1:0]    sum_new;
  logic signed [tkh_pkg::VALUE_W-1:0]  smallest;
  logic                                out_load;

  // Clamp the limit into 1..DEPTH
  always_comb begin
    priority if (keep_limit == '0) begin
      limit = tkh_pkg::CNT_W'(1);
    end else if (keep_limit > tkh_pkg::CNT_W'(tkh_pkg::DEPTH)) begin
      limit = tkh_pkg::CNT_W'(tkh_pkg::DEPTH);
    end else begin
      limit = keep_limit;
    end
  end

  // Decide the request's path at acceptance
  assign s_axis_tready = (state == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign value         = $signed(s_axis_tdata);
  assign do_append     = (s_axis_tuser == tkh_pkg::ACT_INSERT) && (fill < limit);
  assign do_replace    = (s_axis_tuser == tkh_pkg::ACT_INSERT) && !(fill < limit)
                         && (fill != '0) && (value > root);

  assign cmd.start = accept && (do_append || do_replace);
  assign cmd.down  = !do_append;
  assign cmd.pos   = do_append ? fill[tkh_pkg::ADDR_W-1:0] : '0;
  assign cmd.value = value;
  assign cmd.n     = fill;

  tkh_sift u_sift (
    .clk  (clk),
    .rst  (rst),
    .cmd  (cmd),
    .done (sift_done),
    .root (root)
  );

  // Saturating sum update
  assign sum_wide = {sum[tkh_pkg::SUM_W-1], sum}
                    + (tkh_pkg::SUM_W+1)'(delta);
  always_comb begin
    priority if (sum_wide[tkh_pkg::SUM_W] == sum_wide[tkh_pkg::SUM_W-1]) begin
      sum_sat = sum_wide[tkh_pkg::SUM_W-1:0];
    end else if (sum_wide[tkh_pkg::SUM_W]) begin
      sum_sat = tkh_pkg::SUM_MIN;
    end else begin
      sum_sat = tkh_pkg::SUM_MAX;
    end
  end
  assign sum_new  = kept ? sum_sat : sum;
  assign smallest = (fill == '0) ? '0 : root;
  assign out_load = (state == ST_DONE) && (!m_axis_tvalid || m_axis_tready);

  // Sequencer and control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      keep_limit    <= tkh_pkg::CNT_W'(tkh_pkg::DEPTH);
      fill          <= '0;
      sum           <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (cfg_we) begin
        keep_limit <= cfg_wdata;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            if (do_append) begin
              fill <= fill + tkh_pkg::CNT_W'(1);
            end
            state <= (do_append || do_replace) ? ST_SIFT : ST_DONE;
          end
        end
        ST_SIFT: begin
          if (sift_done) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_load) begin
            sum   <= sum_new;
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
      if (out_load) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  // Request payload and result register
  always_ff @(posedge clk) begin
    if (accept) begin
      kept  <= do_append || do_replace;
      delta <= do_append ? tkh_pkg::DELTA_W'(value)
                         : tkh_pkg::DELTA_W'(value) - tkh_pkg::DELTA_W'(root);
    end
    if (out_load) begin
      m_axis_tdata <= {{(tkh_pkg::OUT_W - tkh_pkg::RES_W){1'b0}}, kept,
                       smallest, fill, sum_new};
    end
  end

`ifndef SYNTHESIS
  // Count never exceeds the heap size
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= tkh_pkg::CNT_W'(tkh_pkg::DEPTH))
    else $error("fill exceeds heap depth");

  // Sift completion only arrives while waiting for it
  a_done_in_sift: assert property (@(posedge clk) disable iff (rst)
    sift_done |-> state == ST_SIFT)
    else $error("sift done outside sift wait");

  // A report leaves count and sum untouched
  a_report_stable: assert property (@(posedge clk) disable iff (rst)
    accept && s_axis_tuser == tkh_pkg::ACT_REPORT |=> $stable(fill) && $stable(sum))
    else $error("report changed state");

  // A report result never claims a kept value
  a_report_not_kept: assert property (@(posedge clk) disable iff (rst)
    accept && s_axis_tuser == tkh_pkg::ACT_REPORT |=> !kept)
    else $error("report flagged as kept");
`endif

endmodule
